/* rtl/core/trimmed_mean_of_samples_macros.svh */
// ----------------------------------------------------------------------------
// Trimmed mean of samples: assertion macros
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_OF_SAMPLES_MACROS_SVH
`define TRIMMED_MEAN_OF_SAMPLES_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TMEAN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define TMEAN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define TMEAN_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TMEAN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/tmean_pkg.sv */
// ----------------------------------------------------------------------------
// Trimmed mean of samples: package
// Port widths, parameter defaults, command and status codes, and states.
// ----------------------------------------------------------------------------
package tmean_pkg;

    localparam int DEF_MAX_SAMPLES = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam int IN_SAMPLE_W = 32;
    localparam int TAIL_W      = 7;
    localparam int AVG_W       = 32;
    localparam int KEPT_W      = 7;
    localparam int STATUS_W    = 2;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SETUP,
        ST_SORT_KEY,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_SUM_START,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

/* rtl/core/trimmed_mean_of_samples.sv */
// ----------------------------------------------------------------------------
// Trimmed mean of samples
// Stores samples, then sorts, trims both tails, sums and divides on finish.
// ----------------------------------------------------------------------------
// An add beat writes the sample memory while fewer than MAX_SAMPLES samples
// are stored, and otherwise sets the overflow flag. A finish beat hands the
// stored samples to a sequencer that drives one memory read port, one write
// port, one adder and one compare/subtract step. After a setup that computes
// the tail and kept counts, it runs an insertion sort over the n samples,
// sums the kept samples between the trimmed tails and divides the sum by the
// kept count with a restoring divider. No input beat is taken while a finish
// beat is in progress; add beats are taken while a result waits on the
// output.
module trimmed_mean_of_samples
    import tmean_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [TAIL_W-1:0]      i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_cmd,
    input  logic [IN_SAMPLE_W-1:0] i_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [AVG_W-1:0]       o_average,
    output logic [KEPT_W-1:0]      o_kept_count,
    output logic [STATUS_W-1:0]    o_status
);

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ACC_W  = SAMPLE_BITS + CNT_W;
    localparam int STEP_W = $clog2(ACC_W);
    localparam int PROD_W = CNT_W + TAIL_W;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_rdata;

    t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_overflow, n_overflow;
    logic [TAIL_W-1:0] r_tail_fraction;
    logic              r_out_valid, n_out_valid;

    logic [CNT_W-1:0]       r_n, n_n;
    logic [CNT_W-1:0]       r_tail, n_tail;
    logic [CNT_W-1:0]       r_kept, n_kept;
    logic [CNT_W-1:0]       r_i, n_i;
    logic [CNT_W-1:0]       r_j, n_j;
    logic [CNT_W-1:0]       r_k, n_k;
    logic [SAMPLE_BITS-1:0] r_key, n_key;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [ACC_W-1:0]       r_quo, n_quo;
    logic [CNT_W-1:0]       r_rem, n_rem;
    logic [STEP_W-1:0]      r_step, n_step;
    t_status                r_status, n_status;
    logic [AVG_W-1:0]       r_avg;
    logic [KEPT_W-1:0]      r_kept_out;
    t_status                r_status_out;

    logic                   w_in_accept;
    logic                   w_out_take;
    logic                   w_load_out;
    logic                   w_mem_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [SAMPLE_BITS-1:0] w_wdata;
    logic [IDX_W-1:0]       w_raddr;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [CNT_W-1:0]       w_i_inc;
    logic [CNT_W-1:0]       w_i_dec;
    logic [CNT_W-1:0]       w_j_dec;
    logic [CNT_W-1:0]       w_j_dec2;
    logic [CNT_W-1:0]       w_k_end;
    logic [PROD_W-1:0]      w_prod;
    logic [ACC_W-1:0]       w_acc_sum;
    logic [CNT_W:0]         w_rem_sh;
    logic                   w_rem_ge;
    logic                   w_shift;

    generate
        if (SAMPLE_BITS <= IN_SAMPLE_W) begin : g_trim
            assign w_sample = i_sample[SAMPLE_BITS-1:0];
        end else begin : g_ext
            assign w_sample = {{(SAMPLE_BITS - IN_SAMPLE_W){1'b0}}, i_sample};
        end
    endgenerate

    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_take  = r_out_valid && i_out_ready;
    assign w_load_out  = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    assign w_i_inc   = r_i + CNT_W'(1);
    assign w_i_dec   = r_i - CNT_W'(1);
    assign w_j_dec   = r_j - CNT_W'(1);
    assign w_j_dec2  = r_j - CNT_W'(2);
    assign w_k_end   = r_n - r_tail;
    assign w_prod    = PROD_W'(r_n) * PROD_W'(r_tail_fraction);
    assign w_acc_sum = r_acc + ACC_W'(r_rdata);
    assign w_shift   = r_rdata > r_key;
    assign w_rem_sh  = {r_rem, r_quo[ACC_W-1]};
    assign w_rem_ge  = w_rem_sh >= {1'b0, r_kept};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept && (i_cmd == CMD_FINISH)) begin
                    n_state = (r_count == '0) ? ST_DONE : ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = (r_n == CNT_W'(1)) ? ST_SUM_START : ST_SORT_KEY;
            end
            ST_SORT_KEY: begin
                n_state = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                if (w_shift) begin
                    n_state = (r_j == CNT_W'(1)) ? ST_SORT_PUT : ST_SORT_CMP;
                end else begin
                    n_state = (w_i_inc == r_n) ? ST_SUM_START : ST_SORT_KEY;
                end
            end
            ST_SORT_PUT: begin
                n_state = (w_i_inc == r_n) ? ST_SUM_START : ST_SORT_KEY;
            end
            ST_SUM_START: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (r_k == w_k_end) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == STEP_W'(ACC_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_mem_we   = 1'b0;
        w_waddr    = r_j[IDX_W-1:0];
        w_wdata    = r_key;
        w_raddr    = r_i[IDX_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                w_mem_we   = w_in_accept && (i_cmd == CMD_ADD)
                             && (r_count < CNT_W'(MAX_SAMPLES));
                w_waddr    = r_count[IDX_W-1:0];
                w_wdata    = w_sample;
            end
            ST_SETUP: begin
                w_raddr = IDX_W'(1);
            end
            ST_SORT_KEY: begin
                w_raddr = w_i_dec[IDX_W-1:0];
            end
            ST_SORT_CMP: begin
                w_mem_we = 1'b1;
                if (w_shift) begin
                    w_wdata = r_rdata;
                    w_raddr = w_j_dec2[IDX_W-1:0];
                end else begin
                    w_raddr = w_i_inc[IDX_W-1:0];
                end
            end
            ST_SORT_PUT: begin
                w_mem_we = 1'b1;
                w_waddr  = '0;
                w_raddr  = w_i_inc[IDX_W-1:0];
            end
            ST_SUM_START: begin
                w_raddr = r_tail[IDX_W-1:0];
            end
            ST_SUM: begin
                w_raddr = r_k[IDX_W-1:0];
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        n_n        = r_n;
        n_tail     = r_tail;
        n_kept     = r_kept;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_key      = r_key;
        n_acc      = r_acc;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_step     = r_step;
        n_status   = r_status;
        n_out_valid = r_out_valid;
        if (w_out_take) begin
            n_out_valid = 1'b0;
        end
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    if (i_cmd == CMD_ADD) begin
                        if (r_count < CNT_W'(MAX_SAMPLES)) begin
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end else begin
                        n_n        = r_count;
                        n_count    = '0;
                        n_overflow = 1'b0;
                        n_quo      = '0;
                        n_kept     = '0;
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                        end else if (r_overflow) begin
                            n_status = STATUS_OVERFLOW;
                        end else begin
                            n_status = STATUS_OK;
                        end
                    end
                end
            end
            ST_PREP: begin
                n_tail = CNT_W'(w_prod >> 8);
            end
            ST_SETUP: begin
                n_kept = r_n - {r_tail[CNT_W-2:0], 1'b0};
                n_i    = CNT_W'(1);
            end
            ST_SORT_KEY: begin
                n_key = r_rdata;
                n_j   = r_i;
            end
            ST_SORT_CMP: begin
                if (w_shift) begin
                    n_j = w_j_dec;
                end else begin
                    n_i = w_i_inc;
                end
            end
            ST_SORT_PUT: begin
                n_i = w_i_inc;
            end
            ST_SUM_START: begin
                n_acc = '0;
                n_k   = r_tail + CNT_W'(1);
            end
            ST_SUM: begin
                n_acc = w_acc_sum;
                if (r_k == w_k_end) begin
                    n_quo  = w_acc_sum;
                    n_rem  = '0;
                    n_step = '0;
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end
            ST_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (w_rem_ge) begin
                    n_rem = CNT_W'(w_rem_sh - {1'b0, r_kept});
                end else begin
                    n_rem = w_rem_sh[CNT_W-1:0];
                end
                n_quo = {r_quo[ACC_W-2:0], w_rem_ge};
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_count         <= '0;
            r_overflow      <= 1'b0;
            r_tail_fraction <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tail_fraction <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_tail   <= n_tail;
        r_kept   <= n_kept;
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_key    <= n_key;
        r_acc    <= n_acc;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_status <= n_status;
        if (w_load_out) begin
            r_avg        <= AVG_W'(r_quo);
            r_kept_out   <= KEPT_W'(r_kept);
            r_status_out <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_average    = r_avg;
    assign o_kept_count = r_kept_out;
    assign o_status     = r_status_out;

`include "trimmed_mean_of_samples_macros.svh"

    `TMEAN_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_SAMPLES))
    `TMEAN_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n,
        w_in_accept && (i_cmd == CMD_FINISH), (r_count == '0) && !r_overflow)
    `TMEAN_ASSERT_NOW(a_rem_below_divisor, i_clk, i_rst_n,
        r_state == ST_DIV, r_rem < r_kept)
    `TMEAN_ASSERT_NOW(a_kept_nonzero, i_clk, i_rst_n,
        (r_state == ST_DONE) && (r_status != STATUS_EMPTY), r_kept != '0)

endmodule
